// ===== rtl/core/cfd_pkg.sv =====
// Shared constants and types for the checksummed frame deframer.
// Used by the deframer core; depends on nothing else.
package cfd_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 64;
  localparam logic [7:0]  FRAME_HEADER     = 8'hA5;
  localparam logic [7:0]  MIN_LENGTH       = 8'd2;
  localparam logic [15:0] TIMEOUT_RESET    = 16'd1000;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_DROP    = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_START  = 7'b0000010,
    ST_SEEK   = 7'b0000100,
    ST_LEN    = 7'b0001000,
    ST_SUM    = 7'b0010000,
    ST_PAY    = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic       frame_end;
    logic [5:0] payload_length;
    logic [6:0] dropped_count;
  } res_t;

endpackage

// ===== rtl/core/cfd_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Has no dependencies.
module cfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/checksummed_frame_deframer_core.sv =====
// Frame deframer core: header, length, payload and 8-bit sum check, with resync.
// Depends on cfd_pkg and on cfd_ram for the byte buffer.
//
// Received bytes and timer ticks come in one word at a time. A tick that does
// not flush is handled in the idle state; a flushing tick also passes through
// the finish state and waits there on any output stall. A byte passes through
// its accept step, a setup step, a scan of the held bytes, the sending of any
// payload words and a final step. A bad check byte or a bad length resumes the
// scan one past its header, so held bytes can be read many times, as when
// headers are nested inside a long bad frame. The core is not ready while it
// scans. The single read port of the buffer RAM delivers one held byte per
// cycle to the shared sum and compare logic while no output stall holds the
// scan. The buffer is circular, so keeping a partial frame only moves a start
// pointer. Results leave through an output register and a one-word staging
// register, so the core stalls only when both are full.
module checksummed_frame_deframer_core #(
  parameter int unsigned BUFFER_DEPTH = cfd_pkg::BUFFER_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [8] frame_end,
                                      // [14:9] payload_length, [21:15] dropped_count
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  import cfd_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned XW = ((CW > 8) ? CW : 8) + 2;

  state_e           state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    start_q, start_d;
  logic [CW-1:0]    p_q, p_d;
  logic [CW-1:0]    h_q, h_d;
  logic [CW-1:0]    base_q, base_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       sum_q, sum_d;
  logic [15:0]      wait_q, wait_d;
  logic [15:0]      wait_inc;
  logic [15:0]      timeout_q;
  logic             pend_v_q;
  res_t             pend_q;
  logic             m_valid_q;
  res_t             m_res_q;
  logic             m_last_q;

  logic             emit_req, emit_ok, flush_req, out_free, out_load, need;
  res_t             emit_res;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [7:0]       rd_data;

  // Buffer position to RAM address, wrapping around the circular buffer.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] st, input logic [CW-1:0] pos);
    logic [XW-1:0] t;
    t = XW'(st) + XW'(pos);
    if (t >= XW'(BUFFER_DEPTH)) begin
      t = t - XW'(BUFFER_DEPTH);
    end
    return t[AW-1:0];
  endfunction

  assign out_free = !m_valid_q || m_axis_tready;
  assign emit_ok  = !pend_v_q || out_free;
  assign wait_inc = wait_q + 16'd1;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    start_d  = start_q;
    p_d      = p_q;
    h_d      = h_q;
    base_d   = base_q;
    len_d    = len_q;
    sum_d    = sum_q;
    wait_d   = wait_q;
    emit_req = 1'b0;
    emit_res = '0;
    flush_req = 1'b0;
    need     = 1'b0;
    we       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser != ACT_BYTE) begin
            if (cnt_q == '0) begin
              wait_d = '0;
            end else if (wait_inc >= timeout_q) begin
              emit_req = 1'b1;
              emit_res.kind = KIND_DROP;
              emit_res.dropped_count = 7'(cnt_q);
              cnt_d   = '0;
              wait_d  = '0;
              state_d = ST_FINISH;
            end else begin
              wait_d = wait_inc;
            end
          end else begin
            wait_d  = '0;
            we      = 1'b1;
            cnt_d   = cnt_q + CW'(1);
            base_d  = '0;
            p_d     = '0;
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        // The fresh byte was written last cycle; read the front of the buffer now.
        p_d     = '0;
        state_d = ST_SEEK;
      end
      ST_SEEK: begin
        if (p_q >= cnt_q) begin
          need = cnt_q > base_q;
          if (!need || emit_ok) begin
            emit_req = need;
            emit_res.kind = KIND_DROP;
            emit_res.dropped_count = 7'(cnt_q - base_q);
            cnt_d   = '0;
            state_d = ST_FINISH;
          end
        end else if (rd_data == FRAME_HEADER) begin
          h_d = p_q;
          if (XW'(p_q) + XW'(1) == XW'(cnt_q)) begin
            need = p_q > base_q;
            if (!need || emit_ok) begin
              emit_req = need;
              emit_res.kind = KIND_DROP;
              emit_res.dropped_count = 7'(p_q - base_q);
              start_d = phys(start_q, p_q);
              cnt_d   = cnt_q - p_q;
              state_d = ST_FINISH;
            end
          end else begin
            p_d     = p_q + CW'(1);
            state_d = ST_LEN;
          end
        end else begin
          p_d = p_q + CW'(1);
        end
      end
      ST_LEN: begin
        len_d = rd_data;
        if (rd_data < MIN_LENGTH || XW'(rd_data) + XW'(2) > XW'(BUFFER_DEPTH)) begin
          // Bad length: resume one past the header, which is where p already is.
          state_d = ST_SEEK;
        end else if (XW'(h_q) + XW'(rd_data) + XW'(2) > XW'(cnt_q)) begin
          // The frame is not complete yet: keep it from its header onward.
          need = h_q > base_q;
          if (!need || emit_ok) begin
            emit_req = need;
            emit_res.kind = KIND_DROP;
            emit_res.dropped_count = 7'(h_q - base_q);
            start_d = phys(start_q, h_q);
            cnt_d   = cnt_q - h_q;
            state_d = ST_FINISH;
          end
        end else begin
          sum_d   = FRAME_HEADER + rd_data;
          p_d     = p_q + CW'(1);
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (XW'(p_q) <= XW'(h_q) + XW'(len_q)) begin
          sum_d = sum_q + rd_data;
          p_d   = p_q + CW'(1);
        end else if (sum_q == rd_data) begin
          need = h_q > base_q;
          if (!need || emit_ok) begin
            emit_req = need;
            emit_res.kind = KIND_DROP;
            emit_res.dropped_count = 7'(h_q - base_q);
            p_d     = h_q + CW'(2);
            state_d = ST_PAY;
          end
        end else begin
          p_d     = h_q + CW'(1);
          state_d = ST_SEEK;
        end
      end
      ST_PAY: begin
        if (emit_ok) begin
          emit_req = 1'b1;
          emit_res.kind = KIND_PAYLOAD;
          emit_res.payload_byte = rd_data;
          emit_res.frame_end = (XW'(p_q) == XW'(h_q) + XW'(len_q));
          emit_res.payload_length = 6'(len_q - 8'd1);
          if (emit_res.frame_end) begin
            base_d  = CW'(XW'(h_q) + XW'(len_q) + XW'(2));
            p_d     = base_d;
            state_d = ST_SEEK;
          end else begin
            p_d = p_q + CW'(1);
          end
        end
      end
      ST_FINISH: begin
        // The staged word is the final result of this input word.
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          flush_req = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign waddr = phys(start_q, cnt_q);
  assign raddr = phys(start_q, p_d);
  assign out_load = (emit_req && emit_ok && pend_v_q) || flush_req;

  cfd_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      start_q   <= '0;
      wait_q    <= '0;
      timeout_q <= TIMEOUT_RESET;
      pend_v_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      start_q <= start_d;
      wait_q  <= wait_d;
      if (cfg_valid_i) begin
        timeout_q <= cfg_data_i;
      end
      if (emit_req && emit_ok) begin
        pend_v_q <= 1'b1;
      end else if (flush_req) begin
        pend_v_q <= 1'b0;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    h_q    <= h_d;
    base_q <= base_d;
    len_q  <= len_d;
    sum_q  <= sum_d;
    if (emit_req && emit_ok) begin
      pend_q <= emit_res;
    end
    if (out_load) begin
      m_res_q  <= pend_q;
      m_last_q <= flush_req;
    end
  end

  assign s_axis_tready  = (state_q == ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign m_axis_tvalid  = m_valid_q;
  assign m_axis_tuser   = m_res_q.kind;
  assign m_axis_tlast   = m_last_q;
  assign m_axis_tdata   = {2'b00, m_res_q.dropped_count, m_res_q.payload_length,
                           m_res_q.frame_end, m_res_q.payload_byte};

  // Nothing may stay staged once the core is ready for the next word.
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_v_q)
    else $error("staged result left behind at idle");

  // Between words the buffer always keeps room for one more byte.
  a_idle_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> XW'(cnt_q) < XW'(BUFFER_DEPTH))
    else $error("buffer full between words");

  // Payload is only sent for a frame whose length passed the check.
  a_pay_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PAY |-> len_q >= MIN_LENGTH && XW'(p_q) <= XW'(h_q) + XW'(len_q))
    else $error("payload read outside the frame");

  // A tick never starts a scan.
  a_tick_no_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != ACT_BYTE |=> state_q != ST_START)
    else $error("tick started a scan");

endmodule
